// File: hdl/ptts_pkg.sv
// ----------------------------------------------------------------------------
// Periodic task tick scheduler package
// Shared constants for the tick scheduler and its slot store.
// ----------------------------------------------------------------------------
`default_nettype none

package ptts_pkg;

  localparam int DEFAULT_TASK_SLOTS = 8;
  localparam int TICK_W             = 32;
  localparam int OP_W               = 2;
  localparam int TASK_W             = 3;
  localparam int TWENTY_W           = 5;
  localparam int SLOT_DATA_W        = 2 * TICK_W;

  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_SETUP = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [TWENTY_W-1:0] TWENTY_GROUP = 5'd20;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 72;

endpackage : ptts_pkg

`default_nettype wire

// File: hdl/ptts_slot_mem.sv
// ----------------------------------------------------------------------------
// Task slot store
// One-port-write, one-port-read synchronous memory holding the period and
// countdown of every slot, with per-entry valid bits so that unwritten
// entries read as zero right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ptts_slot_mem
  import ptts_pkg::*;
#(
  parameter int TASK_SLOTS = DEFAULT_TASK_SLOTS,
  parameter int SLOT_AW    = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   wr_en,
  input  wire logic [SLOT_AW-1:0]     wr_addr,
  input  wire logic [SLOT_DATA_W-1:0] wr_data,
  input  wire logic                   rd_en,
  input  wire logic [SLOT_AW-1:0]     rd_addr,
  output logic      [SLOT_DATA_W-1:0] rd_data
);

  logic [SLOT_DATA_W-1:0] mem [TASK_SLOTS];
  logic [TASK_SLOTS-1:0]  valid_r;
  logic [SLOT_DATA_W-1:0] rd_q_r;
  logic                   rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_q_r : '0;

endmodule : ptts_slot_mem

`default_nettype wire

// File: hdl/periodic_task_tick_scheduler.sv
// ----------------------------------------------------------------------------
// Periodic task tick scheduler
// Counts millisecond ticks, walks the task slots on each tick and reports
// which slot fires, and answers elapsed-time queries.
// ----------------------------------------------------------------------------
// Every word taken on the in_ channel yields exactly one word on the out_
// channel. in_tuser selects the operation: a tick, a slot set-up or an
// elapsed-time query. A set-up writes the slot's period and countdown; a
// period of zero disables the slot.
// The block handles one word at a time. A set-up or a query goes from
// acceptance straight to the result; a tick first walks the slots, all
// of them when no slot fires: the slot walk reads one slot per cycle from
// the slot memory, writes it back in the cycle after, and stops at the
// first slot that fires.
// The result sits in an output register. in_tready returns high once the
// result is loaded there, so one more word may be taken while the receiver
// stalls; its result then waits in the block until the register is free.
// Reset clears the tick count, the twenty-tick counter and all slots.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_tick_scheduler
  import ptts_pkg::*;
#(
  parameter int TASK_SLOTS = DEFAULT_TASK_SLOTS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [2:0] task_index, [34:3] period, [66:35] start_time, rest zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] operation
  input  wire logic [OP_W-1:0]        in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [2:0] fired_task, [3] twenty_tick_pulse, [35:4] now_ticks,
  // [67:36] elapsed_ticks, rest zero
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // [0] fired_valid
  output logic [0:0]                  out_tuser
);

  localparam int SLOT_AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int SLOT_CW = $clog2(TASK_SLOTS + 1);
  localparam int IDX_CMP_W = 6;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [TICK_W-1:0]   tick_count_r, tick_count_nxt;
  logic [TWENTY_W-1:0] twenty_r, twenty_nxt;
  logic [SLOT_CW-1:0]  rd_idx_r, rd_idx_nxt;
  logic                ev_valid_r, ev_valid_nxt;
  logic [SLOT_AW-1:0]  ev_idx_r, ev_idx_nxt;
  logic                res_fired_r, res_fired_nxt;
  logic [TASK_W-1:0]   res_task_r, res_task_nxt;
  logic                res_pulse_r, res_pulse_nxt;
  logic [TICK_W-1:0]   res_elapsed_r, res_elapsed_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                out_fired_r, out_fired_nxt;

  logic [OP_W-1:0]     in_op;
  logic [TASK_W-1:0]   in_idx;
  logic [TICK_W-1:0]   in_period;
  logic [TICK_W-1:0]   in_start;
  logic                in_acc;

  logic                   mem_wr_en;
  logic [SLOT_AW-1:0]     mem_wr_addr;
  logic [SLOT_DATA_W-1:0] mem_wr_data;
  logic                   mem_rd_en;
  logic [SLOT_AW-1:0]     mem_rd_addr;
  logic [SLOT_DATA_W-1:0] mem_rd_data;

  logic [TICK_W-1:0]   ev_countdown;
  logic [TICK_W-1:0]   ev_period;
  logic                ev_fire;
  logic                out_free;

  assign in_op     = in_tuser;
  assign in_idx    = in_tdata[2:0];
  assign in_period = in_tdata[34:3];
  assign in_start  = in_tdata[66:35];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign ev_countdown = mem_rd_data[TICK_W-1:0];
  assign ev_period    = mem_rd_data[SLOT_DATA_W-1:TICK_W];
  assign ev_fire      = (state_r == ST_SCAN) && ev_valid_r &&
                        (ev_countdown == '0) && (ev_period != '0);

  ptts_slot_mem #(
    .TASK_SLOTS (TASK_SLOTS),
    .SLOT_AW    (SLOT_AW)
  ) u_slot_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_comb begin
    state_nxt       = state_r;
    tick_count_nxt  = tick_count_r;
    twenty_nxt      = twenty_r;
    rd_idx_nxt      = rd_idx_r;
    ev_valid_nxt    = 1'b0;
    ev_idx_nxt      = ev_idx_r;
    res_fired_nxt   = res_fired_r;
    res_task_nxt    = res_task_r;
    res_pulse_nxt   = res_pulse_r;
    res_elapsed_nxt = res_elapsed_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;
    out_fired_nxt   = out_fired_r;
    mem_wr_en       = 1'b0;
    mem_wr_addr     = ev_idx_r;
    mem_wr_data     = mem_rd_data;
    mem_rd_en       = 1'b0;
    mem_rd_addr     = rd_idx_r[SLOT_AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_fired_nxt   = 1'b0;
          res_task_nxt    = '0;
          res_pulse_nxt   = 1'b0;
          res_elapsed_nxt = '0;
          rd_idx_nxt      = '0;
          state_nxt       = ST_DONE;
          case (in_op)
            OP_TICK: begin
              tick_count_nxt = tick_count_r + TICK_W'(1);
              if (twenty_r + TWENTY_W'(1) == TWENTY_GROUP) begin
                twenty_nxt    = '0;
                res_pulse_nxt = 1'b1;
              end else begin
                twenty_nxt = twenty_r + TWENTY_W'(1);
              end
              state_nxt = ST_SCAN;
            end
            OP_SETUP: begin
              if (IDX_CMP_W'(in_idx) < IDX_CMP_W'(TASK_SLOTS)) begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = SLOT_AW'(in_idx);
                mem_wr_data = {in_period, in_period};
              end
            end
            OP_QUERY: begin
              res_elapsed_nxt = tick_count_r - in_start;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (ev_valid_r) begin
          if (ev_countdown != '0) begin
            mem_wr_en   = 1'b1;
            mem_wr_data = {ev_period, ev_countdown - TICK_W'(1)};
          end else if (ev_period != '0) begin
            mem_wr_en   = 1'b1;
            mem_wr_data = {ev_period, ev_period};
          end
        end
        if (ev_fire) begin
          res_fired_nxt = 1'b1;
          res_task_nxt  = TASK_W'(ev_idx_r);
          state_nxt     = ST_DONE;
        end else if (ev_valid_r && ev_idx_r == SLOT_AW'(TASK_SLOTS - 1)) begin
          state_nxt = ST_DONE;
        end else if (rd_idx_r != SLOT_CW'(TASK_SLOTS)) begin
          mem_rd_en    = 1'b1;
          ev_valid_nxt = 1'b1;
          ev_idx_nxt   = rd_idx_r[SLOT_AW-1:0];
          rd_idx_nxt   = rd_idx_r + SLOT_CW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_fired_nxt = res_fired_r;
          out_data_nxt  = {4'b0000, res_elapsed_r, tick_count_r, res_pulse_r,
                           res_task_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tick_count_r <= '0;
      twenty_r     <= '0;
      rd_idx_r     <= '0;
      ev_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tick_count_r <= tick_count_nxt;
      twenty_r     <= twenty_nxt;
      rd_idx_r     <= rd_idx_nxt;
      ev_valid_r   <= ev_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_idx_r      <= ev_idx_nxt;
    res_fired_r   <= res_fired_nxt;
    res_task_r    <= res_task_nxt;
    res_pulse_r   <= res_pulse_nxt;
    res_elapsed_r <= res_elapsed_nxt;
    out_data_r    <= out_data_nxt;
    out_fired_r   <= out_fired_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_fired_r;

endmodule : periodic_task_tick_scheduler

`default_nettype wire
